@@ rtl/core/ipvf_pkg.sv @@
package ipvf_pkg;

   // stream layout
   localparam int FRAME_HDR_BYTES = 14;
   localparam int IP_HDR_BYTES    = 20;
   localparam int HDR_BYTES       = FRAME_HDR_BYTES + IP_HDR_BYTES;

   // stream positions of the ip header fields that get rewritten or captured
   localparam int POS_TLEN_HI = FRAME_HDR_BYTES + 2;
   localparam int POS_TLEN_LO = FRAME_HDR_BYTES + 3;
   localparam int POS_FLAGS   = FRAME_HDR_BYTES + 6;
   localparam int POS_OFF_LO  = FRAME_HDR_BYTES + 7;
   localparam int POS_HDR_END = HDR_BYTES - 1;

   // byte position counter, saturating well past any payload
   localparam int POS_W = 17;
   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

   // header store: two banks of 64 byte slots, 34 used in each
   localparam int HDR_IDX_W  = 6;
   localparam int MEM_ADDR_W = HDR_IDX_W + 1;
   localparam int MEM_DEPTH  = 2 ** MEM_ADDR_W;

   // work queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // pending header emissions per bank, never more than the queue holds
   localparam int BUSY_W = QUEUE_CW;

   localparam logic [15:0] MTU_RESET  = 16'd1514;
   localparam logic [15:0] MIN_FRAG   = 16'd8;
   localparam logic [7:0]  MF_BIT     = 8'h20;
   localparam logic [7:0]  FLAGS_MASK = 8'hE0;
   localparam int          OFF_W      = 13;

   // one queued unit of work: a payload byte, optionally preceded by a header
   typedef struct packed {
      logic        hdr;
      logic        bank;
      logic [15:0] tlen;
      logic [7:0]  flags_off_hi;
      logic [7:0]  off_lo;
      logic [7:0]  data;
      logic        eof;
      logic        eop;
   } work_type;

   typedef struct packed {
      logic                  en;
      logic [MEM_ADDR_W-1:0] addr;
      logic [7:0]            data;
   } store_wr_type;

   typedef struct packed {
      logic en;
      logic bank;
   } hdr_done_type;

   function automatic logic [15:0] frag_size(input logic [15:0] mtu);
      logic [15:0] d;
      d = 16'd0;
      if (mtu >= 16'(HDR_BYTES)) begin
         d = (mtu - 16'(HDR_BYTES)) & ~16'h7;
      end
      if (d < MIN_FRAG) begin
         d = MIN_FRAG;
      end
      return d;
   endfunction

endpackage

@@ rtl/core/ipvf_req_if.sv @@
interface ipvf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first;

   modport source (output valid, output data_byte, output first, input ready);
   modport sink   (input valid, input data_byte, input first, output ready);
endinterface

@@ rtl/core/ipvf_rsp_if.sv @@
interface ipvf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       end_of_fragment;
   logic       end_of_packet;

   modport source (output valid, output out_byte, output end_of_fragment,
                   output end_of_packet, input ready);
   modport sink   (input valid, input out_byte, input end_of_fragment,
                   input end_of_packet, output ready);
endinterface

@@ rtl/core/ipvf_front.sv @@
module ipvf_front
   import ipvf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   ipvf_req_if.sink      req_ch,
   input  logic          csr_wr_en,
   input  logic [15:0]   csr_wr_data,
   input  logic          q_not_full,
   input  hdr_done_type  hdr_done,
   output logic          q_push,
   output work_type      q_item,
   output store_wr_type  store_wr
);

   logic [POS_W-1:0] pos_ff, pos_in, pos_eff;
   logic [15:0]      bif_ff, bif_in, bif_eff, bif_next;
   logic [15:0]      rem_ff, rem_in;
   logic [15:0]      fs_ff;
   logic [15:0]      tl_ff;
   logic [2:0]       flg_ff;
   logic [OFF_W-1:0] off_ff;
   logic             wb_ff, wb_in;
   logic [BUSY_W-1:0] busy_ff [2];
   logic [BUSY_W-1:0] busy_in [2];

   logic             accept, is_store, tgt_bank, stall, in_payload;
   logic [15:0]      p, size, tlen;
   logic             last_frag, eop, eof;
   logic [OFF_W-1:0] off;

   always_comb begin
      pos_eff  = req_ch.first ? '0 : pos_ff;
      bif_eff  = req_ch.first ? '0 : bif_ff;
      is_store = pos_eff < POS_W'(HDR_BYTES);
      tgt_bank = (pos_eff == '0) ? ~wb_ff : wb_ff;
      stall    = is_store && (busy_ff[tgt_bank] != '0);
      req_ch.ready = q_not_full && !stall;
      accept   = req_ch.valid && req_ch.ready;

      p         = 16'(pos_eff - POS_W'(HDR_BYTES));
      last_frag = rem_ff <= fs_ff;
      size      = last_frag ? rem_ff : fs_ff;
      tlen      = size + 16'(IP_HDR_BYTES);
      off       = off_ff + p[15:3];
      bif_next  = bif_eff + 16'd1;
      eop       = rem_ff == 16'd1;
      eof       = eop || (bif_next >= fs_ff);
      in_payload = !is_store && (rem_ff != '0);

      q_push              = accept && in_payload;
      q_item.hdr          = bif_eff == '0;
      q_item.bank         = wb_ff;
      q_item.tlen         = tlen;
      q_item.flags_off_hi = {flg_ff, 5'd0} | (last_frag ? 8'd0 : MF_BIT)
                            | {3'd0, off[OFF_W-1:8]};
      q_item.off_lo       = off[7:0];
      q_item.data         = req_ch.data_byte;
      q_item.eof          = eof;
      q_item.eop          = eop;

      store_wr.en   = accept && is_store;
      store_wr.addr = {tgt_bank, pos_eff[HDR_IDX_W-1:0]};
      store_wr.data = req_ch.data_byte;

      pos_in = pos_ff;
      bif_in = bif_ff;
      rem_in = rem_ff;
      wb_in  = wb_ff;
      if (accept) begin
         pos_in = (pos_eff == POS_MAX) ? pos_eff : pos_eff + POS_W'(1);
         bif_in = bif_eff;
         if (pos_eff == '0) begin
            wb_in = ~wb_ff;
         end
         if (pos_eff == POS_W'(POS_HDR_END)) begin
            bif_in = '0;
            rem_in = (tl_ff >= 16'(IP_HDR_BYTES)) ? tl_ff - 16'(IP_HDR_BYTES) : '0;
         end else if (in_payload) begin
            bif_in = eof ? '0 : bif_next;
            rem_in = rem_ff - 16'd1;
         end
      end

      for (int b = 0; b < 2; b++) begin
         busy_in[b] = busy_ff[b];
         if (q_push && q_item.hdr && (q_item.bank == 1'(b))) begin
            busy_in[b] = busy_in[b] + BUSY_W'(1);
         end
         if (hdr_done.en && (hdr_done.bank == 1'(b))) begin
            busy_in[b] = busy_in[b] - BUSY_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         bif_ff     <= '0;
         rem_ff     <= '0;
         wb_ff      <= 1'b0;
         fs_ff      <= frag_size(MTU_RESET);
         busy_ff[0] <= '0;
         busy_ff[1] <= '0;
      end else begin
         pos_ff     <= pos_in;
         bif_ff     <= bif_in;
         rem_ff     <= rem_in;
         wb_ff      <= wb_in;
         busy_ff[0] <= busy_in[0];
         busy_ff[1] <= busy_in[1];
         if (csr_wr_en) begin
            fs_ff <= frag_size(csr_wr_data);
         end
      end
   end

   // captured ip header fields
   always_ff @(posedge clock) begin
      if (accept) begin
         if (pos_eff == POS_W'(POS_TLEN_HI)) begin
            tl_ff[15:8] <= req_ch.data_byte;
         end
         if (pos_eff == POS_W'(POS_TLEN_LO)) begin
            tl_ff[7:0] <= req_ch.data_byte;
         end
         if (pos_eff == POS_W'(POS_FLAGS)) begin
            flg_ff           <= req_ch.data_byte[7:5];
            off_ff[OFF_W-1:8] <= req_ch.data_byte[4:0];
         end
         if (pos_eff == POS_W'(POS_OFF_LO)) begin
            off_ff[7:0] <= req_ch.data_byte;
         end
      end
   end

endmodule

@@ rtl/core/ipvf_queue.sv @@
module ipvf_queue
   import ipvf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_item,
   input  logic     pop,
   output work_type head,
   output logic     not_empty,
   output logic     not_full
);

   work_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CW-1:0]   count_ff, count_in;

   always_comb begin
      not_empty = count_ff != '0;
      not_full  = count_ff != QUEUE_CW'(QUEUE_DEPTH);
      head      = slot_ff[rd_ptr_ff];
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/core/ipvf_back.sv @@
module ipvf_back
   import ipvf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  store_wr_type  store_wr,
   input  work_type      head,
   input  logic          q_not_empty,
   output logic          q_pop,
   output hdr_done_type  hdr_done,
   ipvf_rsp_if.source    rsp_ch
);

   logic [7:0] hdr_mem [MEM_DEPTH];
   logic [7:0] mem_rd_ff;

   logic [HDR_IDX_W-1:0] hcnt_ff, hcnt_in;

   logic       s1_valid_ff, s1_valid_in;
   logic       s1_from_mem_ff, s1_from_mem_in;
   logic [7:0] s1_byte_ff, s1_byte_in;
   logic       s1_eof_ff, s1_eof_in;
   logic       s1_eop_ff, s1_eop_in;

   logic       out_valid_ff;
   logic [7:0] out_byte_ff;
   logic       out_eof_ff, out_eop_ff;

   logic       out_adv, s1_adv, take, in_hdr, mem_rd_en;
   logic [MEM_ADDR_W-1:0] mem_rd_addr;

   always_comb begin
      out_adv = !out_valid_ff || rsp_ch.ready;
      s1_adv  = !s1_valid_ff || out_adv;
      take    = s1_adv && q_not_empty;
      in_hdr  = head.hdr && (hcnt_ff < HDR_IDX_W'(HDR_BYTES));

      mem_rd_addr    = {head.bank, hcnt_ff};
      mem_rd_en      = take && in_hdr;
      q_pop          = take && !in_hdr;
      hdr_done.en    = q_pop && head.hdr;
      hdr_done.bank  = head.bank;

      hcnt_in        = hcnt_ff;
      s1_valid_in    = s1_valid_ff;
      s1_from_mem_in = s1_from_mem_ff;
      s1_byte_in     = s1_byte_ff;
      s1_eof_in      = s1_eof_ff;
      s1_eop_in      = s1_eop_ff;

      if (s1_adv) begin
         s1_valid_in = q_not_empty;
      end
      if (take) begin
         if (in_hdr) begin
            hcnt_in        = hcnt_ff + HDR_IDX_W'(1);
            s1_from_mem_in = 1'b0;
            s1_eof_in      = 1'b0;
            s1_eop_in      = 1'b0;
            // rewritten ip header fields, the rest comes from the store
            unique case (hcnt_ff)
               HDR_IDX_W'(POS_TLEN_HI): s1_byte_in = head.tlen[15:8];
               HDR_IDX_W'(POS_TLEN_LO): s1_byte_in = head.tlen[7:0];
               HDR_IDX_W'(POS_FLAGS):   s1_byte_in = head.flags_off_hi;
               HDR_IDX_W'(POS_OFF_LO):  s1_byte_in = head.off_lo;
               default: begin
                  s1_byte_in     = head.data;
                  s1_from_mem_in = 1'b1;
               end
            endcase
         end else begin
            hcnt_in        = '0;
            s1_from_mem_in = 1'b0;
            s1_byte_in     = head.data;
            s1_eof_in      = head.eof;
            s1_eop_in      = head.eop;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         hdr_mem[store_wr.addr] <= store_wr.data;
      end
      if (mem_rd_en) begin
         mem_rd_ff <= hdr_mem[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hcnt_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         hcnt_ff     <= hcnt_in;
         s1_valid_ff <= s1_valid_in;
         if (out_adv) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_from_mem_ff <= s1_from_mem_in;
      s1_byte_ff     <= s1_byte_in;
      s1_eof_ff      <= s1_eof_in;
      s1_eop_ff      <= s1_eop_in;
      if (out_adv) begin
         out_byte_ff <= s1_from_mem_ff ? mem_rd_ff : s1_byte_ff;
         out_eof_ff  <= s1_eof_ff;
         out_eop_ff  <= s1_eop_ff;
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.out_byte        = out_byte_ff;
   assign rsp_ch.end_of_fragment = out_eof_ff;
   assign rsp_ch.end_of_packet   = out_eop_ff;

endmodule

@@ rtl/core/ipv4_fragmenter.sv @@
// ipv4 fragmenter: takes one packet word (byte) per cycle on req_ch unless stalled,
// a 14-byte link header, a 20-byte ipv4 header without options, then payload; first
// marks the first link header word of a packet. the payload leaves on rsp_ch cut
// into fragments of (mtu - 34) rounded down to a multiple of 8 (at least 8), each
// preceded by the link header and an ip header with new total length, fragment
// offset and MF; the header checksum passes through unchanged. mtu is written
// through csr_wr_en / csr_wr_data (reset value 1514); the user must write it only
// while the block is idle, the block itself does not enforce this. rate: the
// output side sends one word per cycle while the receiver is ready, and each
// fragment adds 34 header words to the output. a 4-entry work queue parts the
// input from the output, and headers live in a two-bank store; the input stalls
// on any word while the queue is full, and on a header word while the bank it
// would overwrite still has fragment headers waiting to go out. a payload word
// passes the queue, s1 and the output register on its way out. no clearing pass.
module ipv4_fragmenter
   import ipvf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ipvf_req_if.sink    req_ch,
   ipvf_rsp_if.source  rsp_ch,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   // front to queue
   logic         q_push;
   work_type     q_item;
   logic         q_not_full;

   // queue to back
   work_type     q_head;
   logic         q_not_empty;
   logic         q_pop;

   // header store writes and per-bank release
   store_wr_type store_wr;
   hdr_done_type hdr_done;

   // front: position tracking, header capture, fragment bookkeeping
   ipvf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_not_full  (q_not_full),
      .hdr_done    (hdr_done),
      .q_push      (q_push),
      .q_item      (q_item),
      .store_wr    (store_wr)
   );

   // work queue, one entry per payload word to send
   ipvf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .pop       (q_pop),
      .head      (q_head),
      .not_empty (q_not_empty),
      .not_full  (q_not_full)
   );

   // back: header store, header replay and output register
   ipvf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .store_wr    (store_wr),
      .head        (q_head),
      .q_not_empty (q_not_empty),
      .q_pop       (q_pop),
      .hdr_done    (hdr_done),
      .rsp_ch      (rsp_ch)
   );

endmodule

@@ rtl/core/ipvf_checker.sv @@
module ipvf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_byte,
   input logic       rsp_eof,
   input logic       rsp_eop
);

   // a stalled word stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   // a stalled word keeps its contents
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_byte) && $stable(rsp_eof) && $stable(rsp_eop))
      else $error("rsp word changed while stalled");

   // the last word of a packet also closes its fragment
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_eop |-> rsp_eof)
      else $error("end of packet without end of fragment");

   // nothing is offered right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind ipv4_fragmenter ipvf_checker u_ipvf_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_byte  (rsp_ch.out_byte),
   .rsp_eof   (rsp_ch.end_of_fragment),
   .rsp_eop   (rsp_ch.end_of_packet)
);

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
   import ipvf_pkg::*;

   localparam int CYCLE_LIMIT        = 200000;
   localparam int RESET_CYCLES       = 11;
   localparam int SETTLE_CYCLES      = 12;   // a few times the word latency through the block
   localparam int HOLD_CYCLES        = 300;  // long receiver hold-off, fills the work queue
   localparam int RANDOM_PHASE_WORDS = 40;
   localparam int MISMATCH_REPORTS   = 10;
   localparam int unsigned POS_LIMIT = 32'h20000;
   localparam logic [15:0] OFF_MASK  = 16'((1 << OFF_W) - 1);

   // one word of a fragment frame as it leaves the block
   typedef struct packed {
      logic [7:0] data;
      logic       eof;
      logic       eop;
   } frag_word_type;

   // predicts the fragment frames for every accepted input word and checks
   // the words that come out against them in order
   class frag_scoreboard;
      logic [7:0]    hdr[HDR_BYTES];     // link and ip header, by stream position
      int unsigned   stream_pos;
      int unsigned   total_len;
      int unsigned   offset_bytes;
      int unsigned   fill;               // payload words in the open fragment
      logic [15:0]   mtu;
      frag_word_type frame_words_due[$];
      int            errors;

      function new();
         foreach (hdr[i]) hdr[i] = 8'h00;
         stream_pos   = 0;
         total_len    = 0;
         offset_bytes = 0;
         fill         = 0;
         mtu          = MTU_RESET;
         errors       = 0;
      endfunction

      function int unsigned frag_bytes();
         int unsigned fs;
         fs = 0;
         if (mtu >= HDR_BYTES) fs = (int'(mtu) - HDR_BYTES) & ~7;
         return (fs < MIN_FRAG) ? MIN_FRAG : fs;
      endfunction

      // link header and rewritten ip header ahead of the fragment at payload position p
      function void queue_headers(int unsigned p, int unsigned fs, int unsigned plen);
         bit             last;
         logic [15:0]    tlen;
         logic [OFF_W-1:0] off;
         logic [7:0]     flags;
         logic [7:0]     b;
         last  = (p + fs >= plen);
         tlen  = 16'(IP_HDR_BYTES + (last ? plen - p : fs));
         off   = OFF_W'((offset_bytes + p) >> 3);
         flags = hdr[POS_FLAGS] & FLAGS_MASK;
         if (!last) flags |= MF_BIT;
         for (int i = 0; i < HDR_BYTES; i++) begin
            case (i)
               POS_TLEN_HI: b = tlen[15:8];
               POS_TLEN_LO: b = tlen[7:0];
               POS_FLAGS:   b = flags | 8'(off >> 8);
               POS_OFF_LO:  b = off[7:0];
               default:     b = hdr[i];
            endcase
            frame_words_due.push_back('{b, 1'b0, 1'b0});
         end
      endfunction

      // returns 0 for a word the block ignores (past the payload)
      function bit take_word(logic [7:0] b, logic first_mark);
         int unsigned pos;
         int unsigned p;
         int unsigned plen;
         int unsigned fs;
         logic        eof;
         logic        eop;
         if (first_mark) begin
            stream_pos = 0;
            fill       = 0;
         end
         pos = stream_pos;
         if (stream_pos < POS_LIMIT) stream_pos++;
         if (pos < HDR_BYTES) begin
            hdr[pos] = b;
            if (pos == POS_HDR_END) begin
               total_len    = 32'({hdr[POS_TLEN_HI], hdr[POS_TLEN_LO]});
               offset_bytes = int'({hdr[POS_FLAGS], hdr[POS_OFF_LO]} & OFF_MASK) << 3;
               fill         = 0;
            end
            return 1'b1;
         end
         p    = pos - HDR_BYTES;
         plen = (total_len >= IP_HDR_BYTES) ? total_len - IP_HDR_BYTES : 0;
         if (p >= plen) return 1'b0;
         fs = frag_bytes();
         if (fill == 0) queue_headers(p, fs, plen);
         fill++;
         eof = 1'b0;
         eop = 1'b0;
         if (p + 1 == plen) begin
            eof = 1'b1;
            eop = 1'b1;
         end else if (fill >= fs) begin
            eof = 1'b1;
         end
         if (eof) fill = 0;
         frame_words_due.push_back('{b, eof, eop});
         return 1'b1;
      endfunction

      function void check_word(logic [7:0] b, logic eof, logic eop);
         frag_word_type want;
         if (frame_words_due.size() == 0) begin
            if (errors < MISMATCH_REPORTS)
               $display("unexpected word: byte %02h eof %0d eop %0d", b, eof, eop);
            errors++;
            return;
         end
         want = frame_words_due.pop_front();
         if (want.data !== b || want.eof !== eof || want.eop !== eop) begin
            if (errors < MISMATCH_REPORTS)
               $display({"mismatch: expected byte %02h eof %0d eop %0d,",
                         " got byte %02h eof %0d eop %0d"},
                        want.data, want.eof, want.eop, b, eof, eop);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   ipvf_req_if req_ch();
   ipvf_rsp_if rsp_ch();

   ipv4_fragmenter DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   frag_scoreboard sb = new();

   bit idle_on;        // random idle bursts on both sides
   bit hold_request;   // asks the receiver for one long hold-off
   int used_words;     // accepted words that the block did not ignore
   int cycles;

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit, reckoned many times over the slowest legal run
   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[ipv4_fragmenter] ERROR");
         $finish;
      end
   end

   // receiver: ready changes at the falling edge; random idle bursts,
   // or one long hold-off when asked for, counted here
   initial begin
      int stall_left;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            stall_left   = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left = $urandom_range(1, 6) - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // every word taken at a rising edge goes to the checker
   always @(posedge clock) begin
      if (rsp_ch.valid && rsp_ch.ready)
         sb.check_word(rsp_ch.out_byte, rsp_ch.end_of_fragment, rsp_ch.end_of_packet);
   end

   // one input word; entered and left at a falling edge, valid stays high
   // between back-to-back words
   task automatic send_word(input logic [7:0] b, input logic first_mark);
      int gap;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 6);
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.first     <= first_mark;
      do @(posedge clock); while (!req_ch.ready);
      if (sb.take_word(b, first_mark)) used_words++;
      @(negedge clock);
   endtask

   // link header, ip header with the given length, flags and offset, then
   // body words; extra words run past the payload, cut abandons the packet
   task automatic send_packet(input int body, input logic [15:0] tlen,
                              input logic [12:0] off, input logic [2:0] flags,
                              input int extra, input int cut, input bit mark,
                              input bit alt_fill);
      int         total;
      logic [7:0] b;
      total = HDR_BYTES + body + extra;
      if (cut > 0 && cut < total) total = cut;
      for (int i = 0; i < total; i++) begin
         case (i)
            POS_TLEN_HI: b = tlen[15:8];
            POS_TLEN_LO: b = tlen[7:0];
            POS_FLAGS:   b = {flags, off[12:8]};
            POS_OFF_LO:  b = off[7:0];
            default:     b = alt_fill ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom);
         endcase
         send_word(b, mark && i == 0);
      end
   endtask

   // mostly well-formed packets with random content; some run past the
   // payload, some carry a short total length, some are abandoned
   task automatic random_packet();
      int          kind;
      int          body;
      int          extra;
      int          cut;
      logic [15:0] tlen;
      logic [12:0] off;
      logic [2:0]  flags;
      kind  = $urandom_range(0, 9);
      body  = $urandom_range(1, 40);
      off   = ($urandom_range(0, 3) == 0) ? 13'(13'h1FFF - $urandom_range(0, 15))
                                          : 13'($urandom);
      flags = 3'($urandom);
      tlen  = 16'(IP_HDR_BYTES + body);
      extra = 0;
      cut   = 0;
      case (kind)
         7: extra = $urandom_range(1, 4);
         8: tlen = 16'($urandom_range(0, IP_HDR_BYTES - 1));
         9: begin
            tlen = 16'($urandom);
            cut  = $urandom_range(1, HDR_BYTES + body - 1);
         end
         default: ;
      endcase
      send_packet(body, tlen, off, flags, extra, cut, 1'b1, 1'b0);
   endtask

   // sender pauses until every fragment word is out, then lets the block settle
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.frame_words_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_mtu(input logic [15:0] value);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.mtu = value;
   endtask

   initial begin
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = 16'h0000;
      req_ch.valid     = 1'b0;
      req_ch.data_byte = 8'h00;
      req_ch.first     = 1'b0;
      idle_on          = 1'b1;
      hold_request     = 1'b0;
      used_words       = 0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset mtu; stream starts with no first mark, payload words 00/ff
      send_packet(5, 16'd25, 13'h0000, 3'b000, 0, 0, 1'b0, 1'b1);
      // zero total length: the payload words are ignored
      send_packet(3, 16'h0000, 13'h0000, 3'b000, 0, 0, 1'b1, 1'b0);
      drain();

      // smallest legal mtu, 8-byte fragments
      write_mtu(16'd42);
      // receiver holds off while the sender keeps offering words
      hold_request = 1'b1;
      // three fragments, df kept on every one, mf on all but the last
      send_packet(17, 16'd37, 13'h0003, 3'b010, 0, 0, 1'b1, 1'b1);
      // words past the payload
      send_packet(3, 16'd23, 13'h0000, 3'b000, 4, 0, 1'b1, 1'b0);
      // first mark in the middle of the ip header
      send_packet(10, 16'd100, 13'h0ABC, 3'b100, 0, 20, 1'b1, 1'b0);
      // largest offset, wraps on the second fragment, all flag bits set
      send_packet(16, 16'd36, 13'h1FFF, 3'b111, 0, 0, 1'b1, 1'b0);
      drain();

      // mtu below a full header plus 8 still gives 8-byte fragments
      write_mtu(16'd30);
      send_packet(9, 16'd29, 13'h0155, 3'b001, 0, 0, 1'b1, 1'b0);
      drain();

      write_mtu(16'hFFFF);
      send_packet(20, 16'd40, 13'h1AAA, 3'b011, 0, 0, 1'b1, 1'b1);
      drain();

      // random packets at a random mtu, run without idling to the end
      idle_on = 1'b0;
      write_mtu(16'($urandom_range(42, 200)));
      used_words = 0;
      while (used_words < RANDOM_PHASE_WORDS) random_packet();
      drain();

      if (sb.errors == 0 && sb.frame_words_due.size() == 0) begin
         $display("[ipv4_fragmenter] OK");
      end else begin
         $display("[ipv4_fragmenter] ERROR");
      end
      $finish;
   end

endmodule
